[src/ppts_pkg.sv]
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types and codes of the preemptive priority task scheduler: item
// codes, the waiting-list entry and the commands that drive the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ppts_pkg;

  // sizes of the waiting list and the fields
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 2;
  localparam int MODE_W      = 2;
  localparam int OUTC_W      = 2;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ = 2'd0,
    MODE_FIN = 2'd1,
    MODE_CLR = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  // result outcomes
  typedef enum logic [OUTC_W-1:0] {
    OUT_NOTHING = 2'd0,
    OUT_STARTED = 2'd1,
    OUT_EMPTY   = 2'd2,
    OUT_FULL    = 2'd3
  } outcome_t;

  // cell chain commands
  typedef enum logic [1:0] {
    CELL_NOP    = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  // one waiting task
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    logic   keep;
    entry_t ent;
  } cell_link_t;

endpackage

`default_nettype wire

[src/ppts_if.sv]
// ----------------------------------------------------------------------------
// ppts_if
// Valid/ready channels of the scheduler: the task event channel and the
// result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppts_in_if;
  logic                      valid;
  logic                      ready;
  logic [ppts_pkg::MODE_W-1:0] mode;
  logic [ppts_pkg::ID_W-1:0]   task_id;
  logic [ppts_pkg::PRIO_W-1:0] task_priority;
  logic                      force_req;

  modport source (output valid, mode, task_id, task_priority, force_req, input ready);
  modport sink (input valid, mode, task_id, task_priority, force_req, output ready);
endinterface

interface ppts_out_if;
  logic                        valid;
  logic                        ready;
  logic [ppts_pkg::OUTC_W-1:0] outcome;
  logic [ppts_pkg::ID_W-1:0]   started_id;
  logic                        cancelled;
  logic [ppts_pkg::ID_W-1:0]   cancelled_id;
  logic [ppts_pkg::CNT_W-1:0]  queue_count;

  modport source (output valid, outcome, started_id, cancelled, cancelled_id, queue_count,
                  input ready);
  modport sink (input valid, outcome, started_id, cancelled, cancelled_id, queue_count,
                output ready);
endinterface

`default_nettype wire

[src/ppts_cell.sv]
// ----------------------------------------------------------------------------
// ppts_cell
// One slot of the waiting list. The list is kept sorted by priority, highest
// first and in arrival order within a priority, so the head is always the
// next task to run. Insert shifts right from the insertion point, pop shifts
// everything left by one.
// ----------------------------------------------------------------------------
`default_nettype none

module ppts_cell (
  input  wire logic                 clk,
  input  wire ppts_pkg::cell_cmd_t  cmd,
  input  wire logic                 occ,
  input  wire ppts_pkg::cell_link_t left_link,
  input  wire ppts_pkg::entry_t     right_ent,
  output ppts_pkg::cell_link_t      link
);

  ppts_pkg::entry_t ent_r;
  ppts_pkg::entry_t ent_nxt;
  logic             keep;

  // entry stays put on insert when it ranks at or above the new task
  assign keep = occ && (ent_r.prio >= cmd.ent.prio);
  assign link = '{keep: keep, ent: ent_r};

  // next entry
  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      ppts_pkg::CELL_INSERT: begin
        if (!keep) begin
          ent_nxt = left_link.keep ? cmd.ent : left_link.ent;
        end
      end
      ppts_pkg::CELL_POP: begin
        ent_nxt = right_ent;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

[src/preemptive_priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_task_scheduler
// Waiting list with one running-task slot; one result item per task event.
// ----------------------------------------------------------------------------
// Each event passes from acceptance to the result item through the accept
// cycle, which also does the insert of an enqueued task, and a state that
// loads the output register, together with the pop of the list head when the
// running slot goes to a waiting task. A new event is taken only once the
// last one has loaded its result; a stalled result holds the next event in
// work and drops the input ready until the output register frees. The waiting
// list is a row of cells kept in priority order, so an insert or a pop is a
// single shift of the whole row and the best task always sits in the head
// cell. One event is in work at a time; a new event is taken while the
// previous result still waits in the output register. queue_count reports
// the number of waiting tasks after the event.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_task_scheduler (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ppts_in_if.sink     in_ch,
  ppts_out_if.source  out_ch
);

  localparam int DEPTH = ppts_pkg::QUEUE_DEPTH;
  localparam int CW    = ppts_pkg::CNT_W;
  localparam int IW    = ppts_pkg::ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       run_v_r, run_v_nxt;
  logic [IW-1:0]              run_id_r, run_id_nxt;
  ppts_pkg::outcome_t         res_outc_r, res_outc_nxt;
  logic [IW-1:0]              res_start_r, res_start_nxt;
  logic                       res_canc_r, res_canc_nxt;
  logic [IW-1:0]              res_canc_id_r, res_canc_id_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ppts_pkg::outcome_t         out_outc_r, out_outc_nxt;
  logic [IW-1:0]              out_start_r, out_start_nxt;
  logic                       out_canc_r, out_canc_nxt;
  logic [IW-1:0]              out_canc_id_r, out_canc_id_nxt;
  logic [CW-1:0]              out_count_r, out_count_nxt;

  ppts_pkg::cell_cmd_t        cmd;
  ppts_pkg::cell_link_t       links [DEPTH];
  logic [DEPTH-1:0]           occ;
  logic                       in_acc;
  logic                       slot_free;
  ppts_pkg::mode_t            in_mode;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_mode   = ppts_pkg::mode_t'(in_ch.mode);

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ppts_pkg::cell_link_t left_l;
    ppts_pkg::entry_t     right_e;

    assign occ[g] = count_r > CW'(g);

    // head cell takes the new task whenever it does not keep its own entry
    if (g == 0) begin : g_head
      assign left_l = '{keep: 1'b1, ent: '0};
    end else begin : g_mid
      assign left_l = links[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = links[g+1].ent;
    end

    ppts_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[g]),
      .left_link (left_l),
      .right_ent (right_e),
      .link      (links[g])
    );
  end

  // event decode and sequencing
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    run_v_nxt       = run_v_r;
    run_id_nxt      = run_id_r;
    res_outc_nxt    = res_outc_r;
    res_start_nxt   = res_start_r;
    res_canc_nxt    = res_canc_r;
    res_canc_id_nxt = res_canc_id_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_outc_nxt    = out_outc_r;
    out_start_nxt   = out_start_r;
    out_canc_nxt    = out_canc_r;
    out_canc_id_nxt = out_canc_id_r;
    out_count_nxt   = out_count_r;
    cmd             = '{op: ppts_pkg::CELL_NOP,
                        ent: '{id: in_ch.task_id, prio: in_ch.task_priority}};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_outc_nxt    = ppts_pkg::OUT_NOTHING;
          res_start_nxt   = '0;
          res_canc_nxt    = 1'b0;
          res_canc_id_nxt = '0;
          state_nxt       = S_EMIT;
          unique case (in_mode)
            ppts_pkg::MODE_ENQ: begin
              if (in_ch.force_req) begin
                // preempt: new task runs at once, list untouched
                res_canc_nxt    = run_v_r;
                res_canc_id_nxt = run_v_r ? run_id_r : '0;
                run_v_nxt       = 1'b1;
                run_id_nxt      = in_ch.task_id;
                res_outc_nxt    = ppts_pkg::OUT_STARTED;
                res_start_nxt   = in_ch.task_id;
              end else if (count_r == CW'(DEPTH)) begin
                res_outc_nxt = ppts_pkg::OUT_FULL;
              end else begin
                cmd.op    = ppts_pkg::CELL_INSERT;
                count_nxt = count_r + CW'(1);
                if (!run_v_r) begin
                  state_nxt = S_POP;
                end
              end
            end
            ppts_pkg::MODE_FIN: begin
              if (run_v_r && (in_ch.task_id == run_id_r)) begin
                run_v_nxt  = 1'b0;
                run_id_nxt = '0;
              end
              if (count_r != '0) begin
                state_nxt = S_POP;
              end else begin
                res_outc_nxt = ppts_pkg::OUT_EMPTY;
              end
            end
            ppts_pkg::MODE_CLR: begin
              res_canc_nxt    = run_v_r;
              res_canc_id_nxt = run_v_r ? run_id_r : '0;
              run_v_nxt       = 1'b0;
              run_id_nxt      = '0;
              count_nxt       = '0;
              res_outc_nxt    = ppts_pkg::OUT_EMPTY;
            end
            default: begin
              res_outc_nxt = ppts_pkg::OUT_NOTHING;
            end
          endcase
        end
      end
      S_POP: begin
        // head cell holds the best waiting task
        if (slot_free) begin
          cmd.op          = ppts_pkg::CELL_POP;
          count_nxt       = count_r - CW'(1);
          run_v_nxt       = 1'b1;
          run_id_nxt      = links[0].ent.id;
          out_valid_nxt   = 1'b1;
          out_outc_nxt    = ppts_pkg::OUT_STARTED;
          out_start_nxt   = links[0].ent.id;
          out_canc_nxt    = res_canc_r;
          out_canc_id_nxt = res_canc_id_r;
          out_count_nxt   = count_r - CW'(1);
          state_nxt       = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_outc_nxt    = res_outc_r;
          out_start_nxt   = res_start_r;
          out_canc_nxt    = res_canc_r;
          out_canc_id_nxt = res_canc_id_r;
          out_count_nxt   = count_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_v_r     <= 1'b0;
      run_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      run_v_r     <= run_v_nxt;
      run_id_r    <= run_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_outc_r    <= res_outc_nxt;
    res_start_r   <= res_start_nxt;
    res_canc_r    <= res_canc_nxt;
    res_canc_id_r <= res_canc_id_nxt;
    out_outc_r    <= out_outc_nxt;
    out_start_r   <= out_start_nxt;
    out_canc_r    <= out_canc_nxt;
    out_canc_id_r <= out_canc_id_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.outcome      = out_outc_r;
  assign out_ch.started_id   = out_start_r;
  assign out_ch.cancelled    = out_canc_r;
  assign out_ch.cancelled_id = out_canc_id_r;
  assign out_ch.queue_count  = out_count_r;

endmodule

`default_nettype wire

[src/ppts_checker.sv]
// ----------------------------------------------------------------------------
// ppts_checker
// Port-level checks of the scheduler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppts_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ppts_pkg::OUTC_W-1:0] outcome,
  input wire logic [ppts_pkg::ID_W-1:0]   started_id,
  input wire logic                        cancelled,
  input wire logic [ppts_pkg::ID_W-1:0]   cancelled_id,
  input wire logic [ppts_pkg::CNT_W-1:0]  queue_count
);

  // no result item right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item shown right after reset");

  // a stalled item stays up
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // list never exceeds its depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> queue_count <= ppts_pkg::CNT_W'(ppts_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  // started id only carries a task on a start
  a_start_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (outcome != ppts_pkg::OUT_STARTED) |-> started_id == '0)
    else $error("started id set without a start");

  // cancellation only by preemption or clear
  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cancelled && (outcome == ppts_pkg::OUT_STARTED ||
                                 outcome == ppts_pkg::OUT_EMPTY)) ||
                  (!cancelled && cancelled_id == '0))
    else $error("bad cancellation report");

endmodule

bind preemptive_priority_task_scheduler ppts_checker u_ppts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .outcome      (out_ch.outcome),
  .started_id   (out_ch.started_id),
  .cancelled    (out_ch.cancelled),
  .cancelled_id (out_ch.cancelled_id),
  .queue_count  (out_ch.queue_count)
);

`default_nettype wire
